FILE: design/ph_sample_average_classify_core_macros.svh
// ----------------------------------------------------------------------------
// ph_sample_average_classify_core_macros.svh
// Assertion macros used by the pH sample averager core.
// ----------------------------------------------------------------------------
`ifndef PH_SAMPLE_AVERAGE_CLASSIFY_CORE_MACROS_SVH
`define PH_SAMPLE_AVERAGE_CLASSIFY_CORE_MACROS_SVH

// Invariant checked at every rising clock edge outside reset (expects clk, rst in scope).
`define PSAC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define PSAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/psac_pkg.sv
// ----------------------------------------------------------------------------
// psac_pkg
// Widths, constants, register codes and config type of the pH averager.
// ----------------------------------------------------------------------------
package psac_pkg;

  localparam int WINDOW   = 6;
  localparam int SAMPLE_W = 12;
  localparam int PH_W     = 14;
  localparam int CLASS_W  = 3;
  localparam int SLOPE_W  = 17;
  localparam int VOFF_W   = 12;
  localparam int DIFF_W   = VOFF_W + 1;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = PH_W + $clog2(WINDOW);

  // shared multiplier operand/product widths
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 19;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // sample -> mV scaling
  localparam int MV_SCALE = 3300;
  localparam int MV_SHIFT = 12;
  // slope product -> 1/256 pH
  localparam int PH_SHIFT   = 8;
  localparam int SLOPE_P_W  = SLOPE_W + DIFF_W;
  localparam int SHIFTED_W  = SLOPE_P_W - PH_SHIFT;
  localparam int RAW_W      = SHIFTED_W + 1;

  localparam logic signed [PH_W-1:0] PH_MIN = PH_W'(-4096);
  localparam logic signed [PH_W-1:0] PH_MAX = PH_W'(8191);

  // floor(sum / WINDOW): bias sum to non-negative, multiply by reciprocal
  localparam int     PH_BIAS  = 4096;
  localparam int     RECIP_K  = 24;
  localparam longint RECIP_L  = ((longint'(1) <<< RECIP_K) + WINDOW - 1) / WINDOW;
  localparam logic [MUL_A_W-2:0] RECIP_M  = (MUL_A_W-1)'(RECIP_L);
  localparam logic [SUM_W-1:0]   SUM_BIAS = SUM_W'(WINDOW * PH_BIAS);
  localparam logic [PH_W-1:0]    Q_BIAS   = PH_W'(PH_BIAS);

  // configuration port
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_SLOPE_GAIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VOLT_OFFSET  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PH_INTERCEPT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STRONG_ACID  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ACID         = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BASE         = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STRONG_BASE  = 3'd6;

  // band codes
  localparam logic [CLASS_W-1:0] CLASS_STRONG_ACID = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_ACID        = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_NEUTRAL     = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_BASE        = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_STRONG_BASE = 3'd4;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope_gain;
    logic        [VOFF_W-1:0]  voltage_offset_mv;
    logic signed [PH_W-1:0]    ph_intercept;
    logic signed [PH_W-1:0]    strong_acid_limit;
    logic signed [PH_W-1:0]    acid_limit;
    logic signed [PH_W-1:0]    base_limit;
    logic signed [PH_W-1:0]    strong_base_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    slope_gain:        SLOPE_W'(-229),
    voltage_offset_mv: VOFF_W'(1650),
    ph_intercept:      PH_W'(1792),
    strong_acid_limit: PH_W'(768),
    acid_limit:        PH_W'(1536),
    base_limit:        PH_W'(2048),
    strong_base_limit: PH_W'(2816)
  };

endpackage

FILE: design/psac_if.sv
// ----------------------------------------------------------------------------
// psac_if
// Valid/ready stream interfaces for probe samples and classified results.
// ----------------------------------------------------------------------------
interface psac_sample_if;
  logic                          valid;
  logic                          ready;
  logic [psac_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface psac_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [psac_pkg::PH_W-1:0] ph_value;
  logic [psac_pkg::CLASS_W-1:0]     ph_class;
  logic                             averaged;
  logic                             clipped;

  modport source (output valid, output ph_value, output ph_class, output averaged,
                  output clipped, input ready);
  modport sink   (input valid, input ph_value, input ph_class, input averaged,
                  input clipped, output ready);
endinterface

FILE: design/psac_regs.sv
// ----------------------------------------------------------------------------
// psac_regs
// APB register file holding probe calibration and band limits.
// ----------------------------------------------------------------------------
module psac_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psac_pkg::ADDR_W-1:0]   paddr,
  input  logic [psac_pkg::DATA_W-1:0]   pwdata,
  output logic [psac_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output psac_pkg::cfg_t                cfg
);

  logic [psac_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[psac_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= psac_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        psac_pkg::REG_SLOPE_GAIN:   cfg.slope_gain        <= pwdata[psac_pkg::SLOPE_W-1:0];
        psac_pkg::REG_VOLT_OFFSET:  cfg.voltage_offset_mv <= pwdata[psac_pkg::VOFF_W-1:0];
        psac_pkg::REG_PH_INTERCEPT: cfg.ph_intercept      <= pwdata[psac_pkg::PH_W-1:0];
        psac_pkg::REG_STRONG_ACID:  cfg.strong_acid_limit <= pwdata[psac_pkg::PH_W-1:0];
        psac_pkg::REG_ACID:         cfg.acid_limit        <= pwdata[psac_pkg::PH_W-1:0];
        psac_pkg::REG_BASE:         cfg.base_limit        <= pwdata[psac_pkg::PH_W-1:0];
        psac_pkg::REG_STRONG_BASE:  cfg.strong_base_limit <= pwdata[psac_pkg::PH_W-1:0];
        default: ;
      endcase
    end
  end

  // signed registers read back sign-extended
  always_comb begin
    case (reg_idx)
      psac_pkg::REG_SLOPE_GAIN:
        prdata = {{(psac_pkg::DATA_W-psac_pkg::SLOPE_W){cfg.slope_gain[psac_pkg::SLOPE_W-1]}},
                  cfg.slope_gain};
      psac_pkg::REG_VOLT_OFFSET:
        prdata = {{(psac_pkg::DATA_W-psac_pkg::VOFF_W){1'b0}}, cfg.voltage_offset_mv};
      psac_pkg::REG_PH_INTERCEPT:
        prdata = {{(psac_pkg::DATA_W-psac_pkg::PH_W){cfg.ph_intercept[psac_pkg::PH_W-1]}},
                  cfg.ph_intercept};
      psac_pkg::REG_STRONG_ACID:
        prdata = {{(psac_pkg::DATA_W-psac_pkg::PH_W){cfg.strong_acid_limit[psac_pkg::PH_W-1]}},
                  cfg.strong_acid_limit};
      psac_pkg::REG_ACID:
        prdata = {{(psac_pkg::DATA_W-psac_pkg::PH_W){cfg.acid_limit[psac_pkg::PH_W-1]}},
                  cfg.acid_limit};
      psac_pkg::REG_BASE:
        prdata = {{(psac_pkg::DATA_W-psac_pkg::PH_W){cfg.base_limit[psac_pkg::PH_W-1]}},
                  cfg.base_limit};
      psac_pkg::REG_STRONG_BASE:
        prdata = {{(psac_pkg::DATA_W-psac_pkg::PH_W){cfg.strong_base_limit[psac_pkg::PH_W-1]}},
                  cfg.strong_base_limit};
      default:
        prdata = '0;
    endcase
  end

endmodule

FILE: design/ph_sample_average_classify_core.sv
// ----------------------------------------------------------------------------
// ph_sample_average_classify_core
// pH probe sample converter, six-sample moving average and band classifier.
// ----------------------------------------------------------------------------
// Each sample beat is converted to mV ((sample*3300)>>12), then to pH in 1/256
// units as ph_intercept + floor(slope_gain*(mV - voltage_offset_mv)/256), saturated
// to [-4096, 8191] (clipped flags it). The value enters a six-entry history ring
// with a running sum. During warm-up (fewer than six samples since reset) the
// result is the current value with averaged = 0; after that it is
// floor(sum/6) with averaged = 1. The band is decided on the exact value
// (the sum against limit*6, not the rounded average). One result beat per
// sample beat. The mV scale, slope product and reciprocal divide run through a
// single shared multiplier stepped by a sequencer that also waits in S_CLS
// while the output register is full, so the sample side stays not-ready from the
// accepting edge until the result is loaded into the output register. The
// output register decouples the two sides: the next sample is accepted while a
// result still waits to be taken. Registers sit on an APB port, byte address
// 4*index, pready always high; write them only while the block is idle.
// ----------------------------------------------------------------------------
module ph_sample_average_classify_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psac_pkg::ADDR_W-1:0]  paddr,
  input  logic [psac_pkg::DATA_W-1:0]  pwdata,
  output logic [psac_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  psac_sample_if.sink                  samples,
  psac_result_if.source                results
);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a sample beat
  localparam logic [2:0] S_MV   = 3'd1;  // mult: sample * 3300
  localparam logic [2:0] S_PH   = 3'd2;  // mult: slope * (mV - offset)
  localparam logic [2:0] S_SAT  = 3'd3;  // add offset, saturate, ring update
  localparam logic [2:0] S_DIV  = 3'd4;  // mult: biased sum * reciprocal
  localparam logic [2:0] S_QUO  = 3'd5;  // quotient and remainder flag
  localparam logic [2:0] S_CLS  = 3'd6;  // band compare, load output

  psac_pkg::cfg_t cfg;

  psac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [2:0] state;
  logic [2:0] state_next;

  logic [psac_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [psac_pkg::MUL_P_W-1:0] prod;
  logic signed [psac_pkg::PH_W-1:0] raw_q;
  logic clip_q;
  logic avg_q;
  logic signed [psac_pkg::PH_W-1:0] quo;
  logic rem_nz;

  // history ring and its bookkeeping
  logic signed [psac_pkg::PH_W-1:0]  ring [psac_pkg::WINDOW];
  logic [psac_pkg::SLOT_W-1:0]       write_slot;
  logic signed [psac_pkg::SUM_W-1:0] run_sum;
  logic [psac_pkg::FILL_W-1:0]       fill_count;
  logic [psac_pkg::FILL_W-1:0]       fill_count_next;

  // output register
  logic                             res_valid;
  logic signed [psac_pkg::PH_W-1:0] res_value;
  logic [psac_pkg::CLASS_W-1:0]     res_class;
  logic                             res_avg;
  logic                             res_clip;
  logic                             out_free;

  logic accept;

  // ---- shared multiplier ----
  logic signed [psac_pkg::MUL_A_W-1:0] mul_a;
  logic signed [psac_pkg::MUL_B_W-1:0] mul_b;
  logic signed [psac_pkg::MUL_P_W-1:0] mul_p;

  logic [psac_pkg::SAMPLE_W-1:0]        mv;
  logic signed [psac_pkg::DIFF_W-1:0]   diff;
  logic [psac_pkg::SUM_W-1:0]           sum_biased;

  logic signed [psac_pkg::SHIFTED_W-1:0] shifted;
  logic signed [psac_pkg::RAW_W-1:0]     raw_full;
  logic signed [psac_pkg::PH_W-1:0]      raw_sat;
  logic                                  raw_clip;
  logic signed [psac_pkg::SUM_W-1:0]     sum_next;

  logic [psac_pkg::PH_W-1:0]  q_biased;
  logic [psac_pkg::SUM_W-1:0] q_times_w;
  logic [psac_pkg::CLASS_W-1:0] cls;

  assign accept   = samples.valid && samples.ready;
  assign out_free = !res_valid || results.ready;
  assign samples.ready = (state == S_IDLE);

  // mV lives in the product register after S_MV
  assign mv   = prod[psac_pkg::MV_SHIFT +: psac_pkg::SAMPLE_W];
  assign diff = $signed({1'b0, mv}) - $signed({1'b0, cfg.voltage_offset_mv});
  assign sum_biased = $unsigned(run_sum) + psac_pkg::SUM_BIAS;

  always_comb begin
    case (state)
      S_MV: begin
        mul_a = psac_pkg::MUL_A_W'(psac_pkg::MV_SCALE);
        mul_b = $signed({{(psac_pkg::MUL_B_W-psac_pkg::SAMPLE_W){1'b0}}, sample_q});
      end
      S_PH: begin
        mul_a = $signed({{(psac_pkg::MUL_A_W-psac_pkg::SLOPE_W){cfg.slope_gain[psac_pkg::SLOPE_W-1]}},
                         cfg.slope_gain});
        mul_b = $signed({{(psac_pkg::MUL_B_W-psac_pkg::DIFF_W){diff[psac_pkg::DIFF_W-1]}}, diff});
      end
      S_DIV: begin
        mul_a = $signed({1'b0, psac_pkg::RECIP_M});
        mul_b = $signed({{(psac_pkg::MUL_B_W-psac_pkg::SUM_W){1'b0}}, sum_biased});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = psac_pkg::MUL_P_W'(mul_a) * psac_pkg::MUL_P_W'(mul_b);

  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  // ---- offset add and saturation (product >>> 8 is a floor) ----
  assign shifted  = prod[psac_pkg::SLOPE_P_W-1:psac_pkg::PH_SHIFT];
  assign raw_full = $signed({{(psac_pkg::RAW_W-psac_pkg::PH_W){cfg.ph_intercept[psac_pkg::PH_W-1]}},
                             cfg.ph_intercept})
                  + $signed({shifted[psac_pkg::SHIFTED_W-1], shifted});

  always_comb begin
    raw_clip = 1'b0;
    raw_sat  = raw_full[psac_pkg::PH_W-1:0];
    if (raw_full < psac_pkg::RAW_W'(psac_pkg::PH_MIN)) begin
      raw_sat  = psac_pkg::PH_MIN;
      raw_clip = 1'b1;
    end else if (raw_full > psac_pkg::RAW_W'(psac_pkg::PH_MAX)) begin
      raw_sat  = psac_pkg::PH_MAX;
      raw_clip = 1'b1;
    end
  end

  assign sum_next = run_sum - psac_pkg::SUM_W'(ring[write_slot])
                  + psac_pkg::SUM_W'(raw_sat);
  assign fill_count_next = (fill_count == psac_pkg::FILL_W'(psac_pkg::WINDOW))
                         ? fill_count : fill_count + 1'b1;

  // ---- quotient of biased sum, remainder check ----
  assign q_biased  = prod[psac_pkg::RECIP_K +: psac_pkg::PH_W];
  assign q_times_w = psac_pkg::SUM_W'(q_biased) * psac_pkg::SUM_W'(psac_pkg::WINDOW);

  // ---- band compare on (quotient, remainder != 0) ----
  // x >= L*W  <=>  q >= L;  x > L*W  <=>  q > L, or q == L with a remainder
  function automatic logic lim_ge(input logic signed [psac_pkg::PH_W-1:0] q,
                                  input logic signed [psac_pkg::PH_W-1:0] lim);
    return q >= lim;
  endfunction

  function automatic logic lim_gt(input logic signed [psac_pkg::PH_W-1:0] q,
                                  input logic nz,
                                  input logic signed [psac_pkg::PH_W-1:0] lim);
    return (q > lim) || ((q == lim) && nz);
  endfunction

  always_comb begin
    if (lim_ge(quo, cfg.strong_base_limit)) begin
      cls = psac_pkg::CLASS_STRONG_BASE;
    end else if (lim_gt(quo, rem_nz, cfg.base_limit)) begin
      cls = psac_pkg::CLASS_BASE;
    end else if (lim_gt(quo, rem_nz, cfg.strong_acid_limit) &&
                 !lim_ge(quo, cfg.acid_limit)) begin
      cls = psac_pkg::CLASS_ACID;
    end else if (!lim_gt(quo, rem_nz, cfg.strong_acid_limit)) begin
      cls = psac_pkg::CLASS_STRONG_ACID;
    end else begin
      cls = psac_pkg::CLASS_NEUTRAL;
    end
  end

  // ---- sequencer ----
  always_comb begin
    case (state)
      S_IDLE:  state_next = accept ? S_MV : S_IDLE;
      S_MV:    state_next = S_PH;
      S_PH:    state_next = S_SAT;
      S_SAT:   state_next = S_DIV;
      S_DIV:   state_next = S_QUO;
      S_QUO:   state_next = S_CLS;
      S_CLS:   state_next = out_free ? S_IDLE : S_CLS;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= samples.sample;
    end
    if (state == S_SAT) begin
      raw_q  <= raw_sat;
      clip_q <= raw_clip;
      avg_q  <= (fill_count_next == psac_pkg::FILL_W'(psac_pkg::WINDOW));
    end
    if (state == S_QUO) begin
      if (avg_q) begin
        quo    <= q_biased - psac_pkg::Q_BIAS;
        rem_nz <= (q_times_w != sum_biased);
      end else begin
        quo    <= raw_q;
        rem_nz <= 1'b0;
      end
    end
  end

  // history ring: cleared at reset, one slot written per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < psac_pkg::WINDOW; i++) begin
        ring[i] <= '0;
      end
      write_slot <= '0;
      run_sum    <= '0;
      fill_count <= '0;
    end else if (state == S_SAT) begin
      ring[write_slot] <= raw_sat;
      run_sum          <= sum_next;
      fill_count       <= fill_count_next;
      write_slot       <= (write_slot == psac_pkg::SLOT_W'(psac_pkg::WINDOW - 1))
                        ? '0 : write_slot + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_CLS && out_free) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLS && out_free) begin
      res_value <= quo;
      res_class <= cls;
      res_avg   <= avg_q;
      res_clip  <= clip_q;
    end
  end

  assign results.valid    = res_valid;
  assign results.ph_value = res_value;
  assign results.ph_class = res_class;
  assign results.averaged = res_avg;
  assign results.clipped  = res_clip;

  // ---- checks ----
`include "ph_sample_average_classify_core_macros.svh"

  `PSAC_ASSERT_ALWAYS(a_fill_range, fill_count <= psac_pkg::FILL_W'(psac_pkg::WINDOW), "fill count past window")
  `PSAC_ASSERT_ALWAYS(a_slot_range, write_slot <= psac_pkg::SLOT_W'(psac_pkg::WINDOW - 1), "write slot past window")
  `PSAC_ASSERT_ALWAYS(a_avg_full, !(results.valid && results.averaged) || (fill_count == psac_pkg::FILL_W'(psac_pkg::WINDOW)), "averaged result before ring full")
  `PSAC_ASSERT_NEXT(a_cls_hold, (state == S_CLS) && res_valid && !results.ready, state == S_CLS, "result dropped while output busy")
  `PSAC_ASSERT_NEXT(a_accept_start, accept, state == S_MV, "accepted sample did not start sequence")

endmodule
